// File: rtl/lcgbrd_pkg.sv
// Package for the bounded random draw core: generator constants, request codes,
// width masks, the narrow-draw shift and the span mask helper.
// Standalone; used by lcg_bounded_random_draw_core and lcgbrd_checker.
package lcgbrd_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned MUL_W  = 18;
    localparam int unsigned PROD_W = HALF_W + MUL_W;

    localparam logic [MUL_W-1:0] LCG_MUL = 18'd214013;
    localparam logic [HALF_W-1:0] LCG_ADD = 32'd2531011;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

    // Mask of the low bits that belong to the selected draw width.
    function automatic t_word width_mask(input logic [1:0] code);
        t_word m;
        begin
            case (code)
                WC_8:    m = 64'h0000_0000_0000_00FF;
                WC_16:   m = 64'h0000_0000_0000_FFFF;
                WC_32:   m = 64'h0000_0000_FFFF_FFFF;
                default: m = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // All ones from bit 0 up to the highest set bit of v.
    function automatic t_word span_mask(input t_word v);
        t_word s;
        begin
            s = v;
            s = s | (s >> 1);
            s = s | (s >> 2);
            s = s | (s >> 4);
            s = s | (s >> 8);
            s = s | (s >> 16);
            s = s | (s >> 32);
            return s;
        end
    endfunction

    // Right shift that brings the top bits of a step word down for narrow draws.
    function automatic logic [4:0] narrow_shift(input logic [1:0] code);
        logic [4:0] sh;
        begin
            case (code)
                WC_8:    sh = 5'd24;
                WC_16:   sh = 5'd16;
                default: sh = 5'd0;
            endcase
            return sh;
        end
    endfunction

endpackage

// File: rtl/lcg_bounded_random_draw_core.sv
// Top level of the bounded random draw core: a 64-bit linear congruential
// generator with rejection sampling, built around one shared 32x18 multiplier.
// Depends on lcgbrd_pkg.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------------
//   request   i_valid / i_ready    i_op, i_width_code, i_low_bound, i_high_bound,
//                                  i_seed_value
//   result    o_valid / o_ready    o_value, o_seed_now
//
// A load-seed request goes from acceptance straight to the state that loads the
// result register. A draw request passes through acceptance, the span, then the
// span mask together with the zero-span test, then a low-half and a high-half
// multiplier state per generator step plus a compare state per candidate (two steps
// per candidate for 64-bit spans of 2^32 or more), and a final state for the add.
// A zero-span draw goes from the mask state straight to the final add.
// The rate is set by the single 32x18 multiplier, which forms each 64-bit step
// from a low-half and then a high-half product.
// Reset is synchronous and active low; it clears the seed, the sequencer and the
// result valid. A stalled result holds in the output register while the block
// takes the next request; it stalls only when a second result is ready to leave.
module lcg_bounded_random_draw_core
    import lcgbrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        i_ready,
    input  logic        i_op,
    input  logic [1:0]  i_width_code,
    input  logic [63:0] i_low_bound,
    input  logic [63:0] i_high_bound,
    input  logic [63:0] i_seed_value,
    output logic        o_valid,
    input  logic        o_ready,
    output logic [63:0] o_value,
    output logic [63:0] o_seed_now
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPAN  = 3'd1;
    localparam logic [2:0] ST_MASK  = 3'd2;
    localparam logic [2:0] ST_MUL0  = 3'd3;
    localparam logic [2:0] ST_MUL1  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]        r_state, n_state;
    t_word             r_seed;
    t_word             r_lo;
    t_word             r_hi;
    t_word             r_span;
    t_word             r_mask;
    t_word             r_cand;
    logic [1:0]        r_wc;
    logic              r_wide;
    logic              r_half;
    logic [HALF_W-1:0] r_hw;
    logic [PROD_W:0]   r_plo;
    logic              r_valid;
    t_word             r_value;
    t_word             r_seed_out;

    logic [HALF_W-1:0] mul_a;
    logic [PROD_W-1:0] prod;
    logic [HALF_W-1:0] step_word;
    t_word             cand_c;
    logic              out_free;
    logic              accept;

    // The shared multiplier: low seed half in ST_MUL0, high half in
    // ST_MUL1.
    assign mul_a = (r_state == ST_MUL0) ? r_seed[HALF_W-1:0] : r_seed[WORD_W-1:HALF_W];
    assign prod  = {{MUL_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, LCG_MUL};

    // Candidate from the newest step word; a wide candidate joins it with the
    // previous word kept as the high half.
    assign step_word = r_seed[WORD_W-1:HALF_W];
    always_comb begin
        if (r_wide) begin
            cand_c = {r_hw, step_word} & r_mask;
        end else begin
            cand_c = {{HALF_W{1'b0}}, step_word >> narrow_shift(r_wc)} & r_mask;
        end
    end

    assign out_free = !r_valid || o_ready;
    assign i_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_op == OP_LOAD) ? ST_FIN : ST_SPAN;
                end
            end
            ST_SPAN:  n_state = ST_MASK;
            ST_MASK:  n_state = (r_span == '0) ? ST_FIN : ST_MUL0;
            ST_MUL0:  n_state = ST_MUL1;
            ST_MUL1:  n_state = (r_wide && !r_half) ? ST_MUL0 : ST_CHECK;
            ST_CHECK: n_state = (cand_c > r_span) ? ST_MUL0 : ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_op == OP_LOAD) begin
                r_seed <= i_seed_value;
            end else if (r_state == ST_MUL1) begin
                r_seed <= {prod[HALF_W-1:0] + HALF_W'(r_plo[PROD_W:HALF_W]),
                           r_plo[HALF_W-1:0]};
            end
            if (r_state == ST_FIN && out_free) begin
                r_valid <= 1'b1;
            end else if (o_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_lo   <= (i_op == OP_LOAD) ? '0 : i_low_bound;
                r_hi   <= i_high_bound;
                r_wc   <= i_width_code;
                r_cand <= '0;
            end
            ST_SPAN: begin
                r_span <= (r_hi - r_lo) & width_mask(r_wc);
                r_lo   <= r_lo & width_mask(r_wc);
            end
            ST_MASK: begin
                r_mask <= span_mask(r_span);
                r_wide <= (r_span[WORD_W-1:HALF_W] != '0);
                r_half <= 1'b0;
                r_cand <= '0;
            end
            ST_MUL0: begin
                r_plo <= {1'b0, prod} + {{(PROD_W-HALF_W+1){1'b0}}, LCG_ADD};
            end
            ST_MUL1: begin
                // The first word of a wide candidate becomes its high half.
                if (r_wide && !r_half) begin
                    r_hw   <= prod[HALF_W-1:0] + HALF_W'(r_plo[PROD_W:HALF_W]);
                    r_half <= 1'b1;
                end
            end
            ST_CHECK: begin
                r_half <= 1'b0;
                r_cand <= cand_c;
            end
            default: begin
            end
        endcase
    end

    // Output register: the final add sits in the cycle that loads it.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_value    <= (r_cand + r_lo) & width_mask(r_wc);
            r_seed_out <= r_seed;
        end
    end

    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_seed_now = r_seed_out;

endmodule

// File: rtl/lcgbrd_checker.sv
// Port-level checker for the bounded random draw core, bound to the top level.
// Depends on lcgbrd_pkg.
module lcgbrd_checker
    import lcgbrd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_op,
    input logic [1:0]  i_width_code,
    input logic [63:0] i_low_bound,
    input logic [63:0] i_high_bound,
    input logic [63:0] i_seed_value,
    input logic        o_valid,
    input logic        o_ready,
    input logic [63:0] o_value,
    input logic [63:0] o_seed_now
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_value) && $stable(o_seed_now))
        else $error("stalled result changed");

    // The block takes one request at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> !i_ready)
        else $error("request accepted while busy");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A load-seed request with a free output returns zero and the new seed.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_op == OP_LOAD) && (!o_valid || o_ready)
        |=> ##1 o_valid && (o_value == '0) && (o_seed_now == $past(i_seed_value, 2)))
        else $error("load-seed result wrong");

endmodule

bind lcg_bounded_random_draw_core lcgbrd_checker u_lcgbrd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .i_ready      (i_ready),
    .i_op         (i_op),
    .i_width_code (i_width_code),
    .i_low_bound  (i_low_bound),
    .i_high_bound (i_high_bound),
    .i_seed_value (i_seed_value),
    .o_valid      (o_valid),
    .o_ready      (o_ready),
    .o_value      (o_value),
    .o_seed_now   (o_seed_now)
);
